[rtl/conv3x3_clamped_border_assert.svh]
// Assertion macros for the 3x3 convolution block.
// Depends on nothing; included by the top level.
`ifndef CONV3X3_CLAMPED_BORDER_ASSERT_SVH
`define CONV3X3_CLAMPED_BORDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CVCB_ASSERT_IMPLIES(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// next-cycle implication, checked out of reset
`define CVCB_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

[rtl/cvcb_pkg.sv]
// Shared constants and types for the 3x3 convolution block.
// Used by the front, queue, back and top level modules.
package cvcb_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int PIXEL_BITS   = 8;
   localparam int COEF_BITS    = 16;
   localparam int COEF_STRIDE  = 16;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS   = 11;
   localparam int ROW_BITS     = 16;
   localparam int KROW_BITS    = 48;
   localparam int SUM_BITS     = 28;
   localparam int PROD_BITS    = PIXEL_BITS + 1 + COEF_BITS;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIDDLE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM = 3'd4;

   // target bits of a request: above-left, above, left, self
   localparam int T_UL = 0;
   localparam int T_U  = 1;
   localparam int T_L  = 2;
   localparam int T_S  = 3;

   typedef logic [2:0][2:0][PIXEL_BITS-1:0] window_type;

   typedef struct packed {
      logic [COL_BITS-1:0]      wlast;
      logic [ROW_BITS-1:0]      hlast;
      logic [2:0][KROW_BITS-1:0] kernel;
   } cfg_type;

   typedef struct packed {
      window_type          win;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic [3:0]          mask;
      logic                row_is0;
      logic                row_is1;
      logic                col_is0;
      logic                col_is1;
   } entry_type;

endpackage

[rtl/cvcb_front.sv]
// Front end: accepts pixels, keeps position counters, line stores and window.
// Pushes one entry per request that produces results. Depends on cvcb_pkg.
module cvcb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  cvcb_pkg::cfg_type              cfg,
   input  logic                           restart,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cvcb_pkg::PIXEL_BITS-1:0] req_pixel,
   input  logic                           q_full,
   output logic                           q_push,
   output cvcb_pkg::entry_type            q_entry
);

   logic [cvcb_pkg::PIXEL_BITS-1:0] older_mem [cvcb_pkg::MAX_WIDTH];
   logic [cvcb_pkg::PIXEL_BITS-1:0] newer_mem [cvcb_pkg::MAX_WIDTH];

   logic [cvcb_pkg::COL_BITS-1:0]   col_ff, col_in;
   logic [cvcb_pkg::ROW_BITS-1:0]   row_ff, row_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic [cvcb_pkg::PIXEL_BITS-1:0] s1_px_ff;
   logic [cvcb_pkg::COL_BITS-1:0]   s1_col_ff;
   logic [cvcb_pkg::ROW_BITS-1:0]   s1_row_ff;
   logic [cvcb_pkg::PIXEL_BITS-1:0] rd_old_ff, rd_new_ff;
   logic                            byp_ff, byp_in;
   logic [cvcb_pkg::PIXEL_BITS-1:0] byp_old_ff, byp_new_ff;
   cvcb_pkg::window_type            win_ff, win_in;

   logic [cvcb_pkg::PIXEL_BITS-1:0] s1_old, s1_new;
   logic                            accept, s1_adv;
   logic [3:0]                      mask;

   assign accept = req_valid && !req_stall;
   assign s1_old = byp_ff ? byp_old_ff : rd_old_ff;
   assign s1_new = byp_ff ? byp_new_ff : rd_new_ff;

   always_comb begin
      mask = '0;
      mask[cvcb_pkg::T_UL] = (s1_row_ff != '0) && (s1_col_ff != '0);
      mask[cvcb_pkg::T_U]  = (s1_row_ff != '0) && (s1_col_ff == cfg.wlast);
      mask[cvcb_pkg::T_L]  = (s1_row_ff == cfg.hlast) && (s1_col_ff != '0);
      mask[cvcb_pkg::T_S]  = (s1_row_ff == cfg.hlast) && (s1_col_ff == cfg.wlast);
   end

   assign s1_adv    = s1_valid_ff && ((mask == '0) || !q_full);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign q_push    = s1_adv && (mask != '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = s1_old;
      win_in[1][2] = s1_new;
      win_in[2][2] = s1_px_ff;
   end

   always_comb begin
      q_entry.win     = win_in;
      q_entry.row     = s1_row_ff;
      q_entry.col     = s1_col_ff;
      q_entry.mask    = mask;
      q_entry.row_is0 = (s1_row_ff == '0);
      q_entry.row_is1 = (s1_row_ff == cvcb_pkg::ROW_BITS'(1));
      q_entry.col_is0 = (s1_col_ff == '0);
      q_entry.col_is1 = (s1_col_ff == cvcb_pkg::COL_BITS'(1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == cfg.wlast) begin
            col_in = '0;
            row_in = (row_ff == cfg.hlast) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign byp_in      = accept ? (s1_valid_ff && (s1_col_ff == col_ff)) : byp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         byp_ff      <= byp_in;
         if (s1_adv) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_pixel;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         byp_old_ff <= s1_new;
         byp_new_ff <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_old_ff <= older_mem[col_ff];
         rd_new_ff <= newer_mem[col_ff];
      end
      if (s1_adv) begin
         older_mem[s1_col_ff] <= s1_new;
         newer_mem[s1_col_ff] <= s1_px_ff;
      end
   end

endmodule

[rtl/cvcb_queue.sv]
// Short entry queue between the front end and the back end.
// Depends on cvcb_pkg.
module cvcb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cvcb_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output cvcb_pkg::entry_type pop_entry
);

   cvcb_pkg::entry_type             slot_ff [cvcb_pkg::QUEUE_DEPTH];
   logic [cvcb_pkg::QPTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [cvcb_pkg::QPTR_BITS:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == (cvcb_pkg::QPTR_BITS + 1)'(cvcb_pkg::QUEUE_DEPTH));
   assign valid     = (cnt_ff != '0);
   assign pop_entry = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

[rtl/cvcb_back.sv]
// Back end: walks the targets of each entry and runs the multiply-add pipeline.
// Stages: issue, products, row sums, output register. Depends on cvcb_pkg.
module cvcb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  cvcb_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  cvcb_pkg::entry_type             q_entry,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [cvcb_pkg::SUM_BITS-1:0] rsp_sum,
   output logic [cvcb_pkg::ROW_BITS-1:0]   rsp_out_row,
   output logic [cvcb_pkg::COL_BITS-1:0]   rsp_out_col,
   output logic                            rsp_last_of_run,
   output logic                            rsp_end_of_image
);

   logic                cur_valid_ff, cur_valid_in;
   cvcb_pkg::entry_type cur_ff;
   logic [3:0]          mask_ff, mask_in;

   logic                a_valid_ff, b_valid_ff, o_valid_ff;
   logic signed [cvcb_pkg::PROD_BITS-1:0] prod_ff [3][3];
   logic signed [cvcb_pkg::SUM_BITS-1:0]  rsum_ff [3];
   logic [cvcb_pkg::ROW_BITS-1:0] a_row_ff, b_row_ff, o_row_ff;
   logic [cvcb_pkg::COL_BITS-1:0] a_col_ff, b_col_ff, o_col_ff;
   logic a_last_ff, b_last_ff, o_last_ff, a_eoi_ff, b_eoi_ff, o_eoi_ff;
   logic signed [cvcb_pkg::SUM_BITS-1:0] o_sum_ff;

   logic       en, up, left, last;
   logic [3:0] sel, rest;
   logic [1:0] ri [3];
   logic [1:0] ci [3];
   logic signed [cvcb_pkg::PROD_BITS-1:0] prod_in [3][3];
   logic signed [cvcb_pkg::COEF_BITS-1:0] coef;
   logic [cvcb_pkg::ROW_BITS-1:0] t_row;
   logic [cvcb_pkg::COL_BITS-1:0] t_col;

   assign en = !(o_valid_ff && rsp_stall);

   always_comb begin
      sel = mask_ff & (~mask_ff + 1'b1);
      rest = mask_ff & ~sel;
      last = (rest == '0);
      up   = sel[cvcb_pkg::T_UL] || sel[cvcb_pkg::T_U];
      left = sel[cvcb_pkg::T_UL] || sel[cvcb_pkg::T_L];
      t_row = up ? cur_ff.row - 1'b1 : cur_ff.row;
      t_col = left ? cur_ff.col - 1'b1 : cur_ff.col;
      if (up) begin
         ri[0] = cur_ff.row_is1 ? 2'd1 : 2'd0;
         ri[1] = 2'd1;
      end else begin
         ri[0] = cur_ff.row_is0 ? 2'd2 : 2'd1;
         ri[1] = 2'd2;
      end
      ri[2] = 2'd2;
      if (left) begin
         ci[0] = cur_ff.col_is1 ? 2'd1 : 2'd0;
         ci[1] = 2'd1;
      end else begin
         ci[0] = cur_ff.col_is0 ? 2'd2 : 2'd1;
         ci[1] = 2'd2;
      end
      ci[2] = 2'd2;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef = cfg.kernel[r][c*cvcb_pkg::COEF_STRIDE +: cvcb_pkg::COEF_BITS];
            prod_in[r][c] = $signed({1'b0, cur_ff.win[ri[r]][ci[c]]}) * coef;
         end
      end
   end

   assign q_pop = en && (!cur_valid_ff || last) && q_valid;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      mask_in      = mask_ff;
      if (en) begin
         if (q_pop) begin
            cur_valid_in = 1'b1;
            mask_in      = q_entry.mask;
         end else if (cur_valid_ff && last) begin
            cur_valid_in = 1'b0;
         end else if (cur_valid_ff) begin
            mask_in = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         mask_ff      <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         mask_ff      <= mask_in;
         if (en) begin
            a_valid_ff <= cur_valid_ff;
            b_valid_ff <= a_valid_ff;
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (en) begin
         prod_ff   <= prod_in;
         a_row_ff  <= t_row;
         a_col_ff  <= t_col;
         a_last_ff <= last;
         a_eoi_ff  <= sel[cvcb_pkg::T_S];
         for (int r = 0; r < 3; r++) begin
            rsum_ff[r] <= cvcb_pkg::SUM_BITS'(prod_ff[r][0])
                        + cvcb_pkg::SUM_BITS'(prod_ff[r][1])
                        + cvcb_pkg::SUM_BITS'(prod_ff[r][2]);
         end
         b_row_ff  <= a_row_ff;
         b_col_ff  <= a_col_ff;
         b_last_ff <= a_last_ff;
         b_eoi_ff  <= a_eoi_ff;
         o_sum_ff  <= rsum_ff[0] + rsum_ff[1] + rsum_ff[2];
         o_row_ff  <= b_row_ff;
         o_col_ff  <= b_col_ff;
         o_last_ff <= b_last_ff;
         o_eoi_ff  <= b_eoi_ff;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_sum          = o_sum_ff;
   assign rsp_out_row      = o_row_ff;
   assign rsp_out_col      = o_col_ff;
   assign rsp_last_of_run  = o_last_ff;
   assign rsp_end_of_image = o_eoi_ff;

endmodule

[rtl/conv3x3_clamped_border.sv]
// 3x3 convolution with replicated border.
// Throughput: one request per cycle, one result per cycle while rsp_stall is low; the back end
// issues one target per cycle, so an edge request with up to four results stalls requests briefly.
// Reset (synchronous): 1024x1024 image, identity kernel, counters and window cleared.
// Top level: configuration registers, front end, queue, back end. Depends on cvcb_pkg.
module conv3x3_clamped_border (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cvcb_pkg::PIXEL_BITS-1:0]       req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cvcb_pkg::SUM_BITS-1:0]  rsp_sum,
   output logic [cvcb_pkg::ROW_BITS-1:0]         rsp_out_row,
   output logic [cvcb_pkg::COL_BITS-1:0]         rsp_out_col,
   output logic                                  rsp_last_of_run,
   output logic                                  rsp_end_of_image,
   input  logic                                  csr_write,
   input  logic [cvcb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [cvcb_pkg::KROW_BITS-1:0]        csr_data
);

`include "conv3x3_clamped_border_assert.svh"

   logic [cvcb_pkg::WIDTH_BITS-1:0] width_ff;
   logic [cvcb_pkg::ROW_BITS-1:0]   height_ff;
   logic [2:0][cvcb_pkg::KROW_BITS-1:0] kernel_ff;
   cvcb_pkg::cfg_type   cfg;
   logic                restart;
   logic                q_push, q_full, q_pop, q_valid;
   cvcb_pkg::entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cvcb_pkg::WIDTH_BITS'(1024);
         height_ff <= cvcb_pkg::ROW_BITS'(1024);
         kernel_ff <= {cvcb_pkg::KROW_BITS'(0), cvcb_pkg::KROW_BITS'(65536),
                       cvcb_pkg::KROW_BITS'(0)};
      end else if (csr_write) begin
         unique case (csr_index)
            cvcb_pkg::CSR_WIDTH:  width_ff     <= csr_data[cvcb_pkg::WIDTH_BITS-1:0];
            cvcb_pkg::CSR_HEIGHT: height_ff    <= csr_data[cvcb_pkg::ROW_BITS-1:0];
            cvcb_pkg::CSR_TOP:    kernel_ff[0] <= csr_data;
            cvcb_pkg::CSR_MIDDLE: kernel_ff[1] <= csr_data;
            cvcb_pkg::CSR_BOTTOM: kernel_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign restart = csr_write
                 && ((csr_index == cvcb_pkg::CSR_WIDTH) || (csr_index == cvcb_pkg::CSR_HEIGHT));

   always_comb begin
      if (width_ff == '0) begin
         cfg.wlast = '0;
      end else if (width_ff > cvcb_pkg::WIDTH_BITS'(cvcb_pkg::MAX_WIDTH)) begin
         cfg.wlast = cvcb_pkg::COL_BITS'(cvcb_pkg::MAX_WIDTH - 1);
      end else begin
         cfg.wlast = cvcb_pkg::COL_BITS'(width_ff - 1'b1);
      end
      cfg.hlast  = (height_ff == '0) ? '0 : height_ff - 1'b1;
      cfg.kernel = kernel_ff;
   end

   cvcb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .restart   (restart),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   cvcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_entry  (pop_entry)
   );

   cvcb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sum          (rsp_sum),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_image (rsp_end_of_image)
   );

   `CVCB_ASSERT_IMPLIES(a_eoi_is_last, clock, reset, rsp_valid && rsp_end_of_image, rsp_last_of_run)
   `CVCB_ASSERT_IMPLIES(a_no_overflow, clock, reset, q_push, !q_full || q_pop)
   `CVCB_ASSERT_IMPLIES(a_no_underflow, clock, reset, q_pop, q_valid)
   `CVCB_ASSERT_NEXT(a_push_fills, clock, reset, q_push, q_valid)

endmodule
